@@ rtl/qtp_pkg.sv @@
// ----------------------------------------------------------------------------
// qtp_pkg
// Types and constants for the quintic trajectory point core.
// ----------------------------------------------------------------------------
`default_nettype none

package qtp_pkg;

   localparam int TICK_W       = 32;
   localparam int POS_W        = 32;
   localparam int RATE_W       = 64;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 32;
   localparam int DMAG_W       = POS_W + 1;
   localparam int SMAG_W       = 36;
   localparam int NUM_W        = DMAG_W + SMAG_W;
   localparam int REM_W        = 2 * TICK_W;
   localparam int TAU_STEPS    = TICK_W;
   localparam int DIV_STEPS    = NUM_W;
   localparam int POW_STAGES   = 6;
   localparam int PIPE_DEPTH   = TAU_STEPS + 1 + POW_STAGES + DIV_STEPS + 1;

   localparam logic [CSR_INDEX_W-1:0] REG_START_TICK     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_DURATION_TICKS = CSR_INDEX_W'(1);

   typedef struct packed {
      logic        [TICK_W-1:0] now_tick;
      logic signed [POS_W-1:0]  start_position;
      logic signed [POS_W-1:0]  end_position;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  position;
      logic signed [RATE_W-1:0] velocity;
      logic signed [RATE_W-1:0] acceleration;
   } rsp_type;

   typedef struct packed {
      logic                     t_one;
      logic        [TICK_W-1:0] rem;
      logic        [TICK_W-1:0] quo;
      logic signed [POS_W-1:0]  p0;
      logic        [DMAG_W-1:0] dmag;
      logic                     dneg;
   } tau_stage_type;

   typedef struct packed {
      logic                     t_one;
      logic        [TICK_W-1:0] t1;
      logic        [TICK_W-1:0] t2;
      logic        [TICK_W-1:0] t3;
      logic        [TICK_W-1:0] t4;
      logic        [TICK_W-1:0] t5;
      logic signed [POS_W-1:0]  p0;
      logic        [DMAG_W-1:0] dmag;
      logic                     dneg;
   } pow_stage_type;

   typedef struct packed {
      logic        [TICK_W:0]   sp;
      logic        [SMAG_W-1:0] vmag;
      logic                     vneg;
      logic        [SMAG_W-1:0] amag;
      logic                     aneg;
      logic signed [POS_W-1:0]  p0;
      logic        [DMAG_W-1:0] dmag;
      logic                     dneg;
   } poly_stage_type;

   typedef struct packed {
      logic        [DMAG_W:0]   off;
      logic        [NUM_W-1:0]  numv;
      logic        [NUM_W-1:0]  numa;
      logic                     vneg;
      logic                     aneg;
      logic signed [POS_W-1:0]  p0;
      logic                     dneg;
   } prod_stage_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  pos;
      logic                     vneg;
      logic                     aneg;
      logic        [REM_W-1:0]  vrem;
      logic        [NUM_W-1:0]  vnq;
      logic        [REM_W-1:0]  arem;
      logic        [NUM_W-1:0]  anq;
   } div_stage_type;

endpackage

`default_nettype wire

@@ rtl/quintic_trajectory_point_core.sv @@
// ----------------------------------------------------------------------------
// quintic_trajectory_point_core
// Minimum-jerk point-to-point trajectory: position, velocity and acceleration
// of one joint at one query tick.
//
// Usage:
//   Input channel: a transaction is taken at each rising edge with start high
//   and busy low. busy is never raised, so a transaction may enter every cycle.
//   Result channel: rsp_valid strobes for one cycle with rsp_data; the result
//   is taken at the edge that ends that cycle. Results leave in input order.
//   Configuration: csr_valid/csr_ready write start_tick (index 0) or
//   duration_ticks (index 1); other indexes are dropped. csr_ready is always
//   high. Write only while no transaction is in flight.
//   Throughput: one transaction per cycle. The depth comes from the 32-step
//   normalized-time divider, four chained power multiplies, and the 69-step
//   velocity and acceleration dividers.
//   Reset: valid bits clear, start_tick returns to 0, duration_ticks to 1.
//   The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_trajectory_point_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire qtp_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   output qtp_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [qtp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [qtp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import qtp_pkg::*;

   logic [TICK_W-1:0]      start_ff;
   logic [TICK_W-1:0]      dur_ff;
   logic [REM_W-1:0]       dd_ff;
   logic [PIPE_DEPTH-1:0]  vld_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;
   rsp_type                rsp_data_in;

   tau_stage_type          tau_ff [TAU_STEPS+1];
   tau_stage_type          tau_in [TAU_STEPS+1];
   pow_stage_type          pow1_ff, pow2_ff, pow3_ff, pow4_ff;
   pow_stage_type          pow1_in, pow2_in, pow3_in, pow4_in;
   poly_stage_type         poly_ff, poly_in;
   prod_stage_type         prod_ff, prod_in;
   div_stage_type          div_ff [DIV_STEPS+1];
   div_stage_type          div_in [DIV_STEPS+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         dur_ff   <= TICK_W'(1);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_START_TICK) begin
            start_ff <= csr_wdata[TICK_W-1:0];
         end else if (csr_index == REG_DURATION_TICKS) begin
            dur_ff <= (csr_wdata[TICK_W-1:0] == '0) ? TICK_W'(1) : csr_wdata[TICK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      dd_ff <= REM_W'(dur_ff) * REM_W'(dur_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], start && !busy};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   always_comb begin
      logic              after_start;
      logic [TICK_W-1:0] elapsed;
      logic signed [DMAG_W-1:0] delta;
      logic [TICK_W:0]   rem2;
      logic              ge;
      // entry: elapsed time, delta
      after_start     = req_data.now_tick > start_ff;
      elapsed         = req_data.now_tick - start_ff;
      delta           = DMAG_W'(req_data.end_position) - DMAG_W'(req_data.start_position);
      tau_in[0].t_one = after_start && (elapsed >= dur_ff);
      tau_in[0].rem   = (after_start && !(elapsed >= dur_ff)) ? elapsed : '0;
      tau_in[0].quo   = '0;
      tau_in[0].p0    = req_data.start_position;
      tau_in[0].dneg  = delta < 0;
      tau_in[0].dmag  = (delta < 0) ? DMAG_W'(-delta) : DMAG_W'(delta);
      // normalized time: one quotient bit per stage
      for (int i = 1; i <= TAU_STEPS; i++) begin
         rem2      = {tau_ff[i-1].rem, 1'b0};
         ge        = rem2 >= {1'b0, dur_ff};
         tau_in[i] = tau_ff[i-1];
         tau_in[i].rem = ge ? TICK_W'(rem2 - {1'b0, dur_ff}) : rem2[TICK_W-1:0];
         tau_in[i].quo = {tau_ff[i-1].quo[TICK_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= TAU_STEPS; i++) begin
         tau_ff[i] <= tau_in[i];
      end
   end

   // powers of tau
   always_comb begin
      logic [REM_W-1:0] prod;
      pow1_in       = '0;
      pow1_in.t_one = tau_ff[TAU_STEPS].t_one;
      pow1_in.t1    = tau_ff[TAU_STEPS].t_one ? '0 : tau_ff[TAU_STEPS].quo;
      pow1_in.p0    = tau_ff[TAU_STEPS].p0;
      pow1_in.dmag  = tau_ff[TAU_STEPS].dmag;
      pow1_in.dneg  = tau_ff[TAU_STEPS].dneg;
      prod          = REM_W'(pow1_in.t1) * REM_W'(pow1_in.t1);
      pow1_in.t2    = prod[REM_W-1:TICK_W];
   end

   always_comb begin
      logic [REM_W-1:0] prod;
      pow2_in    = pow1_ff;
      prod       = REM_W'(pow1_ff.t2) * REM_W'(pow1_ff.t1);
      pow2_in.t3 = prod[REM_W-1:TICK_W];
   end

   always_comb begin
      logic [REM_W-1:0] prod;
      pow3_in    = pow2_ff;
      prod       = REM_W'(pow2_ff.t3) * REM_W'(pow2_ff.t1);
      pow3_in.t4 = prod[REM_W-1:TICK_W];
   end

   always_comb begin
      logic [REM_W-1:0] prod;
      pow4_in    = pow3_ff;
      prod       = REM_W'(pow3_ff.t4) * REM_W'(pow3_ff.t1);
      pow4_in.t5 = prod[REM_W-1:TICK_W];
   end

   // polynomial weights
   always_comb begin
      logic signed [39:0] s1, s2, s3, s4, s5, sv, vv, av;
      s1 = $signed(40'(pow4_ff.t1));
      s2 = $signed(40'(pow4_ff.t2));
      s3 = $signed(40'(pow4_ff.t3));
      s4 = $signed(40'(pow4_ff.t4));
      s5 = $signed(40'(pow4_ff.t5));
      sv = 40'sd6 * s5 - 40'sd15 * s4 + 40'sd10 * s3;
      vv = 40'sd30 * s4 - 40'sd60 * s3 + 40'sd30 * s2;
      av = 40'sd120 * s3 - 40'sd180 * s2 + 40'sd60 * s1;
      poly_in.p0   = pow4_ff.p0;
      poly_in.dmag = pow4_ff.dmag;
      poly_in.dneg = pow4_ff.dneg;
      if (pow4_ff.t_one) begin
         poly_in.sp   = {1'b1, {TICK_W{1'b0}}};
         poly_in.vmag = '0;
         poly_in.vneg = 1'b0;
         poly_in.amag = '0;
         poly_in.aneg = 1'b0;
      end else begin
         if (sv < 0) begin
            poly_in.sp = '0;
         end else if (sv > $signed(40'h1_0000_0000)) begin
            poly_in.sp = {1'b1, {TICK_W{1'b0}}};
         end else begin
            poly_in.sp = sv[TICK_W:0];
         end
         poly_in.vneg = vv < 0;
         poly_in.vmag = (vv < 0) ? SMAG_W'(-vv) : SMAG_W'(vv);
         poly_in.aneg = av < 0;
         poly_in.amag = (av < 0) ? SMAG_W'(-av) : SMAG_W'(av);
      end
   end

   // scale by delta
   always_comb begin
      logic [2*DMAG_W-1:0] off_full;
      off_full     = (2*DMAG_W)'(poly_ff.dmag) * (2*DMAG_W)'(poly_ff.sp);
      prod_in.off  = off_full[2*DMAG_W-1:TICK_W];
      prod_in.numv = NUM_W'(poly_ff.dmag) * NUM_W'(poly_ff.vmag);
      prod_in.numa = NUM_W'(poly_ff.dmag) * NUM_W'(poly_ff.amag);
      prod_in.vneg = poly_ff.dneg ^ poly_ff.vneg;
      prod_in.aneg = poly_ff.dneg ^ poly_ff.aneg;
      prod_in.p0   = poly_ff.p0;
      prod_in.dneg = poly_ff.dneg;
   end

   always_ff @(posedge clock) begin
      pow1_ff <= pow1_in;
      pow2_ff <= pow2_in;
      pow3_ff <= pow3_in;
      pow4_ff <= pow4_in;
      poly_ff <= poly_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      logic signed [DMAG_W+2:0] pos_w;
      logic signed [DMAG_W+2:0] off_s;
      logic [REM_W:0] vr2, ar2;
      logic           vge, age;
      // position with saturation, load dividers
      off_s = $signed({2'b00, prod_ff.off});
      pos_w = (DMAG_W+3)'(prod_ff.p0) + (prod_ff.dneg ? -off_s : off_s);
      if (pos_w > $signed((DMAG_W+3)'(32'sh7FFF_FFFF))) begin
         div_in[0].pos = 32'sh7FFF_FFFF;
      end else if (pos_w < $signed({{(DMAG_W+4-POS_W){1'b1}}, {(POS_W-1){1'b0}}})) begin
         div_in[0].pos = 32'sh8000_0000;
      end else begin
         div_in[0].pos = POS_W'(pos_w);
      end
      div_in[0].vneg = prod_ff.vneg;
      div_in[0].aneg = prod_ff.aneg;
      div_in[0].vrem = '0;
      div_in[0].vnq  = prod_ff.numv;
      div_in[0].arem = '0;
      div_in[0].anq  = prod_ff.numa;
      // velocity over duration and acceleration over duration squared, one bit per stage
      for (int i = 1; i <= DIV_STEPS; i++) begin
         vr2       = {div_ff[i-1].vrem, div_ff[i-1].vnq[NUM_W-1]};
         vge       = vr2 >= (REM_W+1)'(dur_ff);
         ar2       = {div_ff[i-1].arem, div_ff[i-1].anq[NUM_W-1]};
         age       = ar2 >= {1'b0, dd_ff};
         div_in[i] = div_ff[i-1];
         div_in[i].vrem = vge ? REM_W'(vr2 - (REM_W+1)'(dur_ff)) : vr2[REM_W-1:0];
         div_in[i].vnq  = {div_ff[i-1].vnq[NUM_W-2:0], vge};
         div_in[i].arem = age ? REM_W'(ar2 - {1'b0, dd_ff}) : ar2[REM_W-1:0];
         div_in[i].anq  = {div_ff[i-1].anq[NUM_W-2:0], age};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
         div_ff[i] <= div_in[i];
      end
   end

   // saturate rates
   always_comb begin
      logic [NUM_W-1:0] lim;
      lim = NUM_W'(1) << (RATE_W - 1);
      rsp_data_in.position = div_ff[DIV_STEPS].pos;
      if (div_ff[DIV_STEPS].vneg) begin
         rsp_data_in.velocity = (div_ff[DIV_STEPS].vnq > lim) ? {1'b1, {(RATE_W-1){1'b0}}}
                                : -$signed(div_ff[DIV_STEPS].vnq[RATE_W-1:0]);
      end else begin
         rsp_data_in.velocity = (div_ff[DIV_STEPS].vnq >= lim) ? {1'b0, {(RATE_W-1){1'b1}}}
                                : $signed(div_ff[DIV_STEPS].vnq[RATE_W-1:0]);
      end
      if (div_ff[DIV_STEPS].aneg) begin
         rsp_data_in.acceleration = (div_ff[DIV_STEPS].anq > lim)
                                    ? {1'b1, {(RATE_W-1){1'b0}}}
                                    : -$signed(div_ff[DIV_STEPS].anq[RATE_W-1:0]);
      end else begin
         rsp_data_in.acceleration = (div_ff[DIV_STEPS].anq >= lim)
                                    ? {1'b0, {(RATE_W-1){1'b1}}}
                                    : $signed(div_ff[DIV_STEPS].anq[RATE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
